### hdl/playfair_digraph_cipher_6x6_defines.svh
// assertion macros for the 6x6 playfair digraph cipher checker
`ifndef PLAYFAIR_DIGRAPH_CIPHER_6X6_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_6X6_DEFINES_SVH

// same-cycle implication, off while reset is low
`define PFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pfc check failed");

// next-cycle implication, off while reset is low
`define PFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pfc check failed");

// next-cycle implication that also runs through reset
`define PFC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pfc check failed");

`endif

### hdl/pfc_pkg.sv
// shared types, constants and symbol coding for the playfair cipher
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

    localparam int SYM_COUNT = 36;
    localparam int SIDE      = 6;
    localparam int SYM_W     = 6;
    localparam int CHAR_W    = 7;
    localparam int RC_W      = 3;

    typedef logic [SYM_W-1:0]  t_sym;
    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [RC_W-1:0]   t_rc;
    typedef logic [1:0]        t_req;
    typedef logic [1:0]        t_status;

    // request kinds
    localparam t_req REQ_KEY      = 2'd0;
    localparam t_req REQ_KEY_END  = 2'd1;
    localparam t_req REQ_TEXT     = 2'd2;
    localparam t_req REQ_TEXT_END = 2'd3;

    // result status codes
    localparam t_status STAT_OK      = 2'd0;
    localparam t_status STAT_BAD_SYM = 2'd1;
    localparam t_status STAT_NO_KEY  = 2'd2;

    // symbol indices
    localparam t_sym X_INDEX     = 6'd23;
    localparam t_sym DIGIT_BASE  = 6'd26;
    localparam t_sym DIGIT_END   = 6'd35;
    localparam t_sym SPACE_INDEX = 6'd35;
    localparam t_sym INVALID_SYM = 6'd63;
    localparam t_rc  RC_LAST     = 3'(SIDE - 1);

    // ascii characters
    localparam t_char CH_ZERO    = 7'h30;
    localparam t_char CH_ONE     = 7'h31;
    localparam t_char CH_COLON   = 7'd58;
    localparam t_char CH_A       = 7'h41;
    localparam t_char CH_O       = 7'h4F;
    localparam t_char CH_BRACKET = 7'd91;
    localparam t_char CH_SPACE   = 7'h20;

    // what the control hands to the output stage
    typedef struct packed {
        logic    pair;
        t_char   ch0;
        t_char   ch1;
        t_status status;
    } t_load;

    function automatic t_sym decode_symbol(input t_char c);
        t_sym s;
        s = INVALID_SYM;
        if (c == CH_ZERO) begin
            s = 6'(CH_O - CH_A);
        end else if (c >= CH_A && c < CH_BRACKET) begin
            s = 6'(c - CH_A);
        end else if (c >= CH_ONE && c < CH_COLON) begin
            s = 6'(c - CH_ONE) + DIGIT_BASE;
        end else if (c == CH_SPACE) begin
            s = SPACE_INDEX;
        end
        return s;
    endfunction

    function automatic t_char encode_symbol(input t_sym s);
        t_char c;
        if (s < DIGIT_BASE) begin
            c = CH_A + 7'(s);
        end else if (s < DIGIT_END) begin
            c = CH_ONE + 7'(s - DIGIT_BASE);
        end else begin
            c = CH_SPACE;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/pfc_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface pfc_in_if;
    import pfc_pkg::*;

    logic  valid;
    logic  ready;
    t_req  req_type;
    t_char symbol;

    modport source (output valid, output req_type, output symbol, input ready);
    modport sink   (input valid, input req_type, input symbol, output ready);
endinterface

interface pfc_out_if;
    import pfc_pkg::*;

    logic    valid;
    logic    ready;
    t_char   cipher_char;
    logic    last;
    t_status status;

    modport source (output valid, output cipher_char, output last, output status,
                    input ready);
    modport sink   (input valid, input cipher_char, input last, input status,
                    output ready);
endinterface

`default_nettype wire

### hdl/pfc_ram.sv
// 36 x 6 synchronous ram, one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module pfc_ram (
    input  logic          i_clk,
    input  logic          i_we,
    input  pfc_pkg::t_sym i_waddr,
    input  pfc_pkg::t_sym i_wdata,
    input  logic          i_re,
    input  pfc_pkg::t_sym i_raddr_a,
    input  pfc_pkg::t_sym i_raddr_b,
    output pfc_pkg::t_sym o_rdata_a,
    output pfc_pkg::t_sym o_rdata_b
);
    import pfc_pkg::*;

    t_sym r_mem [SYM_COUNT];
    t_sym r_rdata_a;
    t_sym r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

### hdl/pfc_outbuf.sv
// output stage holding one error result or one enciphered pair
`timescale 1ns / 1ps
`default_nettype none

module pfc_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  pfc_pkg::t_load   i_data,
    output logic             o_free,
    pfc_out_if.source        o_res
);
    import pfc_pkg::*;

    logic  r_valid;
    logic  n_valid;
    logic  r_sel;
    logic  n_sel;
    t_load r_data;
    logic  take_final;

    // the final result of the held request leaves this cycle
    assign take_final = r_valid && o_res.ready && (!r_data.pair || r_sel);
    assign o_free     = !r_valid || take_final;

    always_comb begin
        n_valid = r_valid;
        n_sel   = r_sel;
        if (i_load) begin
            n_valid = 1'b1;
            n_sel   = 1'b0;
        end else if (r_valid && o_res.ready) begin
            if (r_data.pair && !r_sel) begin
                n_sel = 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.cipher_char = r_sel ? r_data.ch1 : r_data.ch0;
    assign o_res.last        = !r_data.pair || r_sel;
    assign o_res.status      = r_data.status;

endmodule

`default_nettype wire

### hdl/playfair_digraph_cipher_6x6.sv
// top level of the 6x6 playfair digraph cipher
//
//  channel  | dir | payload                         | handshake
//  ---------+-----+---------------------------------+-------------
//  i_req    | in  | req_type, symbol                | valid/ready
//  o_res    | out | cipher_char, last, status       | valid/ready
//
// an end of key request walks the 36 symbols and writes each unused one to the
//   square; a text symbol or end of text that closes a pair does a place ram
//   read, then a square ram read; an error request waits in the error state
// a request is taken while the previous results still sit in the output stage;
//   the core only waits in its last state until that stage frees up
// reset clears the used marks, fill count and pair state at once; ram contents
//   are never cleared, every cell is written before any text is enciphered
`timescale 1ns / 1ps
`default_nettype none

module playfair_digraph_cipher_6x6 (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfc_in_if.sink    i_req,
    pfc_out_if.source o_res
);
    import pfc_pkg::*;

    // core states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_PLACE = 3'd2;
    localparam logic [2:0] ST_CELL  = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;

    // flat cell address row*6+col
    function automatic t_sym cell_addr(input t_rc row, input t_rc col);
        return t_sym'({row, 2'b00}) + t_sym'({row, 1'b0}) + t_sym'(col);
    endfunction

    // step along a row or column with wrap
    function automatic t_rc next_rc(input t_rc v);
        return (v == RC_LAST) ? '0 : v + 3'd1;
    endfunction

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [SYM_COUNT-1:0] r_used;
    logic [SYM_COUNT-1:0] n_used;
    t_sym                 r_fill;
    t_sym                 n_fill;
    t_rc                  r_fill_row;
    t_rc                  n_fill_row;
    t_rc                  r_fill_col;
    t_rc                  n_fill_col;
    logic                 r_ready;
    logic                 n_ready;
    t_sym                 r_pend;
    t_sym                 n_pend;
    logic                 r_have_pend;
    logic                 n_have_pend;
    t_sym                 r_prev;
    t_sym                 n_prev;
    logic                 r_have_prev;
    logic                 n_have_prev;
    t_sym                 r_walk;
    t_sym                 n_walk;
    t_status              r_err_status;
    t_status              n_err_status;

    logic    in_acc;
    t_sym    sym;
    logic    sym_ok;
    logic    text_ins;
    logic    key_place;
    logic    walk_place;
    logic    mem_we;
    t_sym    wsym;
    logic    pair_go;
    t_sym    pair_a;
    t_sym    pair_b;
    t_sym    place_a;
    t_sym    place_b;
    t_sym    sq_addr_a;
    t_sym    sq_addr_b;
    logic    sq_re;
    t_sym    sq_a;
    t_sym    sq_b;
    t_rc     ra;
    t_rc     ca;
    t_rc     rb;
    t_rc     cb;
    logic    out_free;
    logic    load;
    t_load   ld;

    assign i_req.ready = (r_state == ST_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;

    assign sym      = decode_symbol(i_req.symbol);
    assign sym_ok   = (sym != INVALID_SYM);
    // insert an x between equal neighbors, but never between two x's
    assign text_ins = r_have_prev && (r_prev == sym) && (sym != X_INDEX);

    // square fill: a fresh key symbol, or an unused symbol during the walk
    assign key_place  = in_acc && (i_req.req_type == REQ_KEY) && !r_ready && sym_ok
                        && !r_used[sym] && (r_fill < t_sym'(SYM_COUNT));
    assign walk_place = (r_state == ST_WALK) && !r_used[r_walk];
    assign mem_we     = key_place || walk_place;
    assign wsym       = (r_state == ST_WALK) ? r_walk : sym;

    // writes only happen before the square is ready and reads only after,
    // so the two rams never see a read and write of the same entry overlap
    pfc_ram u_square (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (r_fill),
        .i_wdata   (wsym),
        .i_re      (sq_re),
        .i_raddr_a (sq_addr_a),
        .i_raddr_b (sq_addr_b),
        .o_rdata_a (sq_a),
        .o_rdata_b (sq_b)
    );

    // place entries hold {row, col} so no divide by six is needed
    pfc_ram u_place (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (wsym),
        .i_wdata   ({r_fill_row, r_fill_col}),
        .i_re      (pair_go),
        .i_raddr_a (pair_a),
        .i_raddr_b (pair_b),
        .o_rdata_a (place_a),
        .o_rdata_b (place_b)
    );

    // pair rule on the looked-up places
    assign ra = place_a[SYM_W-1:RC_W];
    assign ca = place_a[RC_W-1:0];
    assign rb = place_b[SYM_W-1:RC_W];
    assign cb = place_b[RC_W-1:0];
    assign sq_re = (r_state == ST_PLACE);

    always_comb begin
        if (ra == rb) begin
            // same row: shift right
            sq_addr_a = cell_addr(ra, next_rc(ca));
            sq_addr_b = cell_addr(rb, next_rc(cb));
        end else if (ca == cb) begin
            // same column: shift down
            sq_addr_a = cell_addr(next_rc(ra), ca);
            sq_addr_b = cell_addr(next_rc(rb), cb);
        end else begin
            // rectangle: swap columns
            sq_addr_a = cell_addr(ra, cb);
            sq_addr_b = cell_addr(rb, ca);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_fill       = r_fill;
        n_fill_row   = r_fill_row;
        n_fill_col   = r_fill_col;
        n_ready      = r_ready;
        n_pend       = r_pend;
        n_have_pend  = r_have_pend;
        n_prev       = r_prev;
        n_have_prev  = r_have_prev;
        n_walk       = r_walk;
        n_err_status = r_err_status;
        pair_go      = 1'b0;
        pair_a       = r_pend;
        pair_b       = X_INDEX;
        load         = 1'b0;
        ld           = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_req.req_type)
                        REQ_KEY: begin
                            if (!r_ready && !sym_ok) begin
                                n_err_status = STAT_BAD_SYM;
                                n_state      = ST_ERR;
                            end
                        end
                        REQ_KEY_END: begin
                            if (!r_ready) begin
                                n_walk  = '0;
                                n_state = ST_WALK;
                            end
                        end
                        REQ_TEXT: begin
                            if (!r_ready) begin
                                n_err_status = STAT_NO_KEY;
                                n_state      = ST_ERR;
                            end else if (!sym_ok) begin
                                n_err_status = STAT_BAD_SYM;
                                n_state      = ST_ERR;
                            end else begin
                                if (r_have_pend) begin
                                    // close the open pair; with an x between,
                                    // this symbol opens the next one
                                    pair_go     = 1'b1;
                                    pair_a      = r_pend;
                                    pair_b      = text_ins ? X_INDEX : sym;
                                    n_pend      = sym;
                                    n_have_pend = text_ins;
                                end else if (text_ins) begin
                                    pair_go     = 1'b1;
                                    pair_a      = X_INDEX;
                                    pair_b      = sym;
                                    n_have_pend = 1'b0;
                                end else begin
                                    n_pend      = sym;
                                    n_have_pend = 1'b1;
                                end
                                n_prev      = sym;
                                n_have_prev = 1'b1;
                            end
                        end
                        REQ_TEXT_END: begin
                            if (!r_ready) begin
                                n_err_status = STAT_NO_KEY;
                                n_state      = ST_ERR;
                            end else begin
                                // pad an odd tail with x
                                pair_go     = r_have_pend;
                                pair_a      = r_pend;
                                pair_b      = X_INDEX;
                                n_have_pend = 1'b0;
                                n_have_prev = 1'b0;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                    if (pair_go) begin
                        n_state = ST_PLACE;
                    end
                end
            end
            ST_WALK: begin
                if (r_walk == SPACE_INDEX) begin
                    n_ready = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_walk = r_walk + 6'd1;
                end
            end
            ST_PLACE: begin
                n_state = ST_CELL;
            end
            ST_CELL: begin
                // square read data holds until the output stage takes it
                if (out_free) begin
                    load       = 1'b1;
                    ld.pair    = 1'b1;
                    ld.ch0     = encode_symbol(sq_a);
                    ld.ch1     = encode_symbol(sq_b);
                    ld.status  = STAT_OK;
                    n_state    = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    load      = 1'b1;
                    ld.pair   = 1'b0;
                    ld.status = r_err_status;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // fill bookkeeping follows every square write
        if (mem_we) begin
            n_used[wsym] = 1'b1;
            n_fill       = r_fill + 6'd1;
            if (r_fill_col == RC_LAST) begin
                n_fill_col = '0;
                n_fill_row = r_fill_row + 3'd1;
            end else begin
                n_fill_col = r_fill_col + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_fill      <= '0;
            r_fill_row  <= '0;
            r_fill_col  <= '0;
            r_ready     <= 1'b0;
            r_pend      <= '0;
            r_have_pend <= 1'b0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_walk      <= '0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_fill      <= n_fill;
            r_fill_row  <= n_fill_row;
            r_fill_col  <= n_fill_col;
            r_ready     <= n_ready;
            r_pend      <= n_pend;
            r_have_pend <= n_have_pend;
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
            r_walk      <= n_walk;
        end
    end

    // error status is payload
    always_ff @(posedge i_clk) begin
        r_err_status <= n_err_status;
    end

    pfc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_data  (ld),
        .o_free  (out_free),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

### hdl/pfc_checker.sv
// port-level checks for the playfair cipher result channel
`timescale 1ns / 1ps
`default_nettype none
`include "playfair_digraph_cipher_6x6_defines.svh"

module pfc_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  pfc_pkg::t_char   i_out_char,
    input  logic             i_out_last,
    input  pfc_pkg::t_status i_out_status
);
    import pfc_pkg::*;

    logic              first_taken;
    logic              second_shown;
    logic              error_shown;
    logic              stall_seen;
    logic [CHAR_W+2:0] res_word;

    assign first_taken  = i_out_valid && i_out_ready && !i_out_last && (i_out_status == STAT_OK);
    assign second_shown = i_out_valid && i_out_last && (i_out_status == STAT_OK);
    assign error_shown  = i_out_valid && (i_out_status != STAT_OK);
    assign stall_seen   = i_out_valid && !i_out_ready;
    assign res_word     = {i_out_char, i_out_last, i_out_status};

    // nothing is offered right after reset
    `PFC_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !i_out_valid)

    // the first half of a pair is followed at once by its second half
    `PFC_ASSERT_NEXT(a_pair_second, i_clk, i_rst_n, first_taken, second_shown)

    // an error result is a single result with a zero character
    `PFC_ASSERT_NOW(a_error_form, i_clk, i_rst_n, error_shown, i_out_last && (i_out_char == '0))

    // a stalled result holds
    `PFC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, stall_seen, i_out_valid && $stable(res_word))

endmodule

bind playfair_digraph_cipher_6x6 pfc_checker u_pfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_char   (o_res.cipher_char),
    .i_out_last   (o_res.last),
    .i_out_status (o_res.status)
);

`default_nettype wire
